>>> rtl/core/pbte_pkg.sv
// shared types and constants for the prism base triangle embedding unit
`default_nettype none

package pbte_pkg;

   localparam int unsigned SQ_STEPS  = 32;
   localparam int unsigned DIV_STEPS = 32;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_TRI = 2'd1,
      ST_COS = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0]        edge_len_0;
      logic [31:0]        edge_len_1;
      logic [31:0]        edge_len_2;
      logic signed [31:0] height_0;
      logic signed [31:0] height_1;
      logic signed [31:0] height_2;
   } req_type;

   typedef struct packed {
      logic [31:0]        base_len_0;
      logic [31:0]        base_len_1;
      logic [31:0]        base_len_2;
      logic signed [31:0] apex_x;
      logic [31:0]        apex_y;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/pbte_if.sv
// valid/ready channel interfaces for request and response beats
`default_nettype none

interface pbte_req_if;
   import pbte_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pbte_rsp_if;
   import pbte_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pbte_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module pbte_isqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] rad_in,
   output logic      [31:0] root_out
);
   import pbte_pkg::*;

   logic [32:0] rem_ff  [0:SQ_STEPS-2];
   logic [63:0] rad_ff  [0:SQ_STEPS-2];
   logic [31:0] root_ff [0:SQ_STEPS-1];

   genvar g;
   generate
      for (g = 0; g < SQ_STEPS; g++) begin : g_step
         logic [32:0] rem_prev;
         logic [31:0] root_prev;
         logic [63:0] rad_prev;
         logic [34:0] acc;
         logic [34:0] trial;
         logic [34:0] acc_sub;
         logic        fit;

         if (g == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
         end else begin : g_next
            assign rem_prev  = rem_ff[g-1];
            assign root_prev = root_ff[g-1];
            assign rad_prev  = rad_ff[g-1];
         end

         // bring down two radicand bits, try root*4+1
         assign acc     = {rem_prev, rad_prev[63:62]};
         assign trial   = {1'b0, root_prev, 2'b01};
         assign acc_sub = acc - trial;
         assign fit     = (acc >= trial);

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff[g] <= {root_prev[30:0], fit};
            end
         end

         if (g < SQ_STEPS - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[g] <= fit ? acc_sub[32:0] : acc[32:0];
                  rad_ff[g] <= {rad_prev[61:0], 2'b00};
               end
            end
         end
      end
   endgenerate

   assign root_out = root_ff[SQ_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/pbte_div.sv
// pipelined restoring divider, 64 by 32 bits to a 32-bit quotient
`default_nettype none

module pbte_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] dvd_in,
   input  wire logic [31:0] dvs_in,
   output logic      [31:0] quo_out
);
   import pbte_pkg::*;

   logic [31:0] rem_ff [0:DIV_STEPS-2];
   logic [31:0] low_ff [0:DIV_STEPS-2];
   logic [31:0] dvs_ff [0:DIV_STEPS-2];
   logic [31:0] quo_ff [0:DIV_STEPS-1];

   genvar g;
   generate
      for (g = 0; g < DIV_STEPS; g++) begin : g_step
         logic [31:0] rem_prev;
         logic [31:0] low_prev;
         logic [31:0] dvs_prev;
         logic [31:0] quo_prev;
         logic [32:0] acc;
         logic [32:0] acc_sub;
         logic        fit;

         if (g == 0) begin : g_first
            // upper half already below the divisor when the quotient fits
            assign rem_prev = dvd_in[63:32];
            assign low_prev = dvd_in[31:0];
            assign dvs_prev = dvs_in;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[g-1];
            assign low_prev = low_ff[g-1];
            assign dvs_prev = dvs_ff[g-1];
            assign quo_prev = quo_ff[g-1];
         end

         assign acc     = {rem_prev, low_prev[31]};
         assign acc_sub = acc - {1'b0, dvs_prev};
         assign fit     = (acc >= {1'b0, dvs_prev});

         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[g] <= {quo_prev[30:0], fit};
            end
         end

         if (g < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[g] <= fit ? acc_sub[31:0] : acc[31:0];
                  low_ff[g] <= {low_prev[30:0], 1'b0};
                  dvs_ff[g] <= dvs_prev;
               end
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/prism_base_triangle_embed_unit.sv
// top level: base triangle of a triangular prism from side lengths and heights
`default_nettype none

// Takes the three slanted side lengths and three vertex heights of a prism and
// returns the projected base sides, the apex of the base triangle placed with
// vertex 0 at the origin and vertex 1 on the x axis, and a status code. All
// values are fixed point and the arithmetic is scale free, so any fraction
// width works. The datapath is one pipeline of 106 register stages: squaring,
// three parallel 32-stage square roots, the cosine-law checks, a 32-stage
// divider for apex_x, and a last 32-stage square root for apex_y. A beat
// enters every cycle, and its result leaves from the response register. The
// whole pipeline stalls together only while a finished result waits on the
// response side; a bubble never stops intake.
module prism_base_triangle_embed_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   pbte_req_if.sink    req_chan,
   pbte_rsp_if.source  rsp_chan
);
   import pbte_pkg::*;

   // side band that travels next to the first square roots
   typedef struct packed {
      logic       vld;
      status_type status;
   } sq_side_type;

   // side band that travels next to the divider
   typedef struct packed {
      logic       vld;
      status_type status;
      logic [31:0] b0;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [63:0] s1;
      logic        neg;
      logic        ovf;
   } div_side_type;

   // side band that travels next to the apex square root
   typedef struct packed {
      logic       vld;
      status_type status;
      logic [31:0] b0;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [31:0] xs;
   } y_side_type;

   logic adv;

   // stage 1: height differences
   logic        p1_vld_ff;
   logic [31:0] p1_len_ff [0:2];
   logic [31:0] p1_ad_ff  [0:2];
   logic [31:0] p1_ad_in  [0:2];

   // stage 2: squares
   logic        p2_vld_ff;
   logic [63:0] p2_l2_ff [0:2];
   logic [63:0] p2_d2_ff [0:2];

   // stage 3: radicands
   logic        p3_vld_ff;
   logic        p3_tri_ff;
   logic [63:0] p3_rad_ff [0:2];

   logic [31:0] base_root [0:2];
   sq_side_type sq_side_ff [0:SQ_STEPS-1];
   sq_side_type sq_side_in;

   // stage 4: checks and squared bases
   logic        p4_vld_ff;
   status_type  p4_status_ff;
   status_type  p4_status_in;
   logic [31:0] p4_b_ff [0:2];
   logic [63:0] p4_s1_ff;
   logic [63:0] p4_s2_ff;
   logic [63:0] p4_c2_ff;

   // stage 5: b1^2 + b2^2
   logic        p5_vld_ff;
   status_type  p5_status_ff;
   logic [31:0] p5_b_ff [0:2];
   logic [63:0] p5_s1_ff;
   logic [63:0] p5_c2_ff;
   logic [64:0] p5_lo_ff;

   // stage 6: sign and half magnitude of the cosine numerator
   logic        p6_vld_ff;
   status_type  p6_status_ff;
   logic [31:0] p6_b_ff [0:2];
   logic [63:0] p6_s1_ff;
   logic        p6_neg_ff;
   logic [63:0] p6_half_ff;
   logic [65:0] p6_pos_diff;
   logic [64:0] p6_neg_diff;

   logic [31:0]  quo;
   div_side_type div_side_ff [0:DIV_STEPS-1];
   div_side_type div_side_in;
   div_side_type div_last;

   // stage 7: clamped magnitude of apex_x
   logic        p7_vld_ff;
   status_type  p7_status_ff;
   logic [31:0] p7_b_ff [0:2];
   logic [63:0] p7_s1_ff;
   logic        p7_neg_ff;
   logic [31:0] p7_mag_ff;
   logic [31:0] p7_mag_in;

   // stage 8: mag^2 and saturated apex_x
   logic        p8_vld_ff;
   status_type  p8_status_ff;
   logic [31:0] p8_b_ff [0:2];
   logic [63:0] p8_s1_ff;
   logic [63:0] p8_mm_ff;
   logic [31:0] p8_xs_ff;
   logic [31:0] p8_xs_in;

   // stage 9: apex radicand
   logic [63:0] p9_y2_ff;
   y_side_type  y_side_ff [0:SQ_STEPS-1];
   y_side_type  y_side_in;
   y_side_type  y_last;
   logic [31:0] apex_root;

   // response register
   logic    rsp_vld_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // whole pipe moves unless a finished beat is held at the output
   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !reset;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      logic        [32:0] m;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? (33'd0 - d) : d;
      return m[31:0];
   endfunction

   function automatic logic corner_bad(input logic [31:0] c,
                                       input logic [31:0] a,
                                       input logic [31:0] b);
      logic [32:0] sum;
      logic [31:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = (a > b) ? (a - b) : (b - a);
      return ({1'b0, c} > sum) || (diff > c);
   endfunction

   always_comb begin
      p1_ad_in[0] = abs_diff(req_chan.data.height_1, req_chan.data.height_2);
      p1_ad_in[1] = abs_diff(req_chan.data.height_2, req_chan.data.height_0);
      p1_ad_in[2] = abs_diff(req_chan.data.height_0, req_chan.data.height_1);
   end

   // stages 1 to 3
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= req_chan.valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_len_ff[0] <= req_chan.data.edge_len_0;
         p1_len_ff[1] <= req_chan.data.edge_len_1;
         p1_len_ff[2] <= req_chan.data.edge_len_2;
         for (int i = 0; i < 3; i++) begin
            p1_ad_ff[i]  <= p1_ad_in[i];
            p2_l2_ff[i]  <= 64'(p1_len_ff[i]) * 64'(p1_len_ff[i]);
            p2_d2_ff[i]  <= 64'(p1_ad_ff[i]) * 64'(p1_ad_ff[i]);
            p3_rad_ff[i] <= p2_l2_ff[i] - p2_d2_ff[i];
         end
         // a slanted side shorter than its height step cannot close
         p3_tri_ff <= (p2_l2_ff[0] < p2_d2_ff[0]) || (p2_l2_ff[1] < p2_d2_ff[1]) ||
                      (p2_l2_ff[2] < p2_d2_ff[2]);
      end
   end

   // projected base sides
   genvar gi;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_base
         pbte_isqrt u_isqrt (
            .clock    (clock),
            .en       (adv),
            .rad_in   (p3_rad_ff[gi]),
            .root_out (base_root[gi])
         );
      end
   endgenerate

   assign sq_side_in.vld    = p3_vld_ff;
   assign sq_side_in.status = p3_tri_ff ? ST_TRI : ST_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_STEPS; k++) begin
            sq_side_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         sq_side_ff[0] <= sq_side_in;
         for (int k = 1; k < SQ_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // stage 4: degenerate and cosine range checks, squares of the bases
   always_comb begin
      p4_status_in = sq_side_ff[SQ_STEPS-1].status;
      if (p4_status_in == ST_OK) begin
         if ((base_root[0] == '0) || (base_root[1] == '0) || (base_root[2] == '0) ||
             corner_bad(base_root[0], base_root[1], base_root[2]) ||
             corner_bad(base_root[1], base_root[2], base_root[0]) ||
             corner_bad(base_root[2], base_root[0], base_root[1])) begin
            p4_status_in = ST_COS;
         end
      end
   end

   assign p6_pos_diff = {1'b0, p5_lo_ff} - {2'b00, p5_c2_ff};
   assign p6_neg_diff = {1'b0, p5_c2_ff} - p5_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else if (adv) begin
         p4_vld_ff <= sq_side_ff[SQ_STEPS-1].vld;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_status_ff <= p4_status_in;
         for (int i = 0; i < 3; i++) begin
            p4_b_ff[i] <= base_root[i];
            p5_b_ff[i] <= p4_b_ff[i];
            p6_b_ff[i] <= p5_b_ff[i];
         end
         p4_s1_ff <= 64'(base_root[1]) * 64'(base_root[1]);
         p4_s2_ff <= 64'(base_root[2]) * 64'(base_root[2]);
         p4_c2_ff <= 64'(base_root[0]) * 64'(base_root[0]);

         p5_status_ff <= p4_status_ff;
         p5_s1_ff     <= p4_s1_ff;
         p5_c2_ff     <= p4_c2_ff;
         p5_lo_ff     <= {1'b0, p4_s1_ff} + {1'b0, p4_s2_ff};

         // numerator b1^2 + b2^2 - b0^2 may be 65 bits either way
         p6_status_ff <= p5_status_ff;
         p6_s1_ff     <= p5_s1_ff;
         p6_neg_ff    <= p6_pos_diff[65];
         p6_half_ff   <= p6_pos_diff[65] ? p6_neg_diff[64:1] : p6_pos_diff[64:1];
      end
   end

   // apex_x magnitude = half / b2
   pbte_div u_div (
      .clock   (clock),
      .en      (adv),
      .dvd_in  (p6_half_ff),
      .dvs_in  (p6_b_ff[2]),
      .quo_out (quo)
   );

   assign div_side_in.vld    = p6_vld_ff;
   assign div_side_in.status = p6_status_ff;
   assign div_side_in.b0     = p6_b_ff[0];
   assign div_side_in.b1     = p6_b_ff[1];
   assign div_side_in.b2     = p6_b_ff[2];
   assign div_side_in.s1     = p6_s1_ff;
   assign div_side_in.neg    = p6_neg_ff;
   // quotient does not fit 32 bits, so it is beyond b1 anyway
   assign div_side_in.ovf    = (p6_half_ff[63:32] >= p6_b_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            div_side_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         div_side_ff[0] <= div_side_in;
         for (int k = 1; k < DIV_STEPS; k++) begin
            div_side_ff[k] <= div_side_ff[k-1];
         end
      end
   end

   assign div_last  = div_side_ff[DIV_STEPS-1];
   assign p7_mag_in = (div_last.ovf || (quo > div_last.b1)) ? div_last.b1 : quo;

   // saturate to the signed output range
   always_comb begin
      if (p7_neg_ff) begin
         p8_xs_in = (p7_mag_ff > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - p7_mag_ff);
      end else begin
         p8_xs_in = (p7_mag_ff > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : p7_mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
         p8_vld_ff <= 1'b0;
      end else if (adv) begin
         p7_vld_ff <= div_last.vld;
         p8_vld_ff <= p7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_status_ff <= div_last.status;
         p7_b_ff[0]   <= div_last.b0;
         p7_b_ff[1]   <= div_last.b1;
         p7_b_ff[2]   <= div_last.b2;
         p7_s1_ff     <= div_last.s1;
         p7_neg_ff    <= div_last.neg;
         p7_mag_ff    <= p7_mag_in;

         p8_status_ff <= p7_status_ff;
         for (int i = 0; i < 3; i++) begin
            p8_b_ff[i] <= p7_b_ff[i];
         end
         p8_s1_ff <= p7_s1_ff;
         p8_mm_ff <= 64'(p7_mag_ff) * 64'(p7_mag_ff);
         p8_xs_ff <= p8_xs_in;

         // mag never exceeds b1, so this stays non-negative
         p9_y2_ff <= p8_s1_ff - p8_mm_ff;
      end
   end

   // stage 9 side band enters the apex root line
   y_side_type p9_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p9_side_ff.vld <= 1'b0;
      end else if (adv) begin
         p9_side_ff.vld    <= p8_vld_ff;
         p9_side_ff.status <= p8_status_ff;
         p9_side_ff.b0     <= p8_b_ff[0];
         p9_side_ff.b1     <= p8_b_ff[1];
         p9_side_ff.b2     <= p8_b_ff[2];
         p9_side_ff.xs     <= p8_xs_ff;
      end
   end

   assign y_side_in = p9_side_ff;

   pbte_isqrt u_apex_isqrt (
      .clock    (clock),
      .en       (adv),
      .rad_in   (p9_y2_ff),
      .root_out (apex_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_STEPS; k++) begin
            y_side_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         y_side_ff[0] <= y_side_in;
         for (int k = 1; k < SQ_STEPS; k++) begin
            y_side_ff[k] <= y_side_ff[k-1];
         end
      end
   end

   assign y_last = y_side_ff[SQ_STEPS-1];

   // any failure clears every coordinate
   always_comb begin
      rsp_data_in.status = y_last.status;
      if (y_last.status == ST_OK) begin
         rsp_data_in.base_len_0 = y_last.b0;
         rsp_data_in.base_len_1 = y_last.b1;
         rsp_data_in.base_len_2 = y_last.b2;
         rsp_data_in.apex_x     = y_last.xs;
         rsp_data_in.apex_y     = apex_root;
      end else begin
         rsp_data_in.base_len_0 = '0;
         rsp_data_in.base_len_1 = '0;
         rsp_data_in.base_len_2 = '0;
         rsp_data_in.apex_x     = '0;
         rsp_data_in.apex_y     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= y_last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/pbte_checker.sv
// port-level checks on the prism base triangle embedding unit
`default_nettype none

module pbte_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire pbte_pkg::rsp_type rsp_data
);
   import pbte_pkg::*;

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // a failed triangle carries no coordinates
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
         (rsp_data.base_len_0 == '0) && (rsp_data.base_len_1 == '0) &&
         (rsp_data.base_len_2 == '0) && (rsp_data.apex_x == '0) &&
         (rsp_data.apex_y == '0))
      else $error("non-zero coordinates on a failed beat");

   // a good triangle has a real base and an apex no higher than its side
   a_ok_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_OK) |->
         (rsp_data.base_len_2 != '0) && (rsp_data.apex_y <= rsp_data.base_len_1))
      else $error("inconsistent triangle on a good beat");

   // intake stops together with a held result
   a_stall_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the pipeline is stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind prism_base_triangle_embed_unit pbte_checker u_pbte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
